// ----- hdl/mpt_pkg.sv -----
package mpt_pkg;

    localparam int POS_W       = 13;
    localparam int BTN_N       = 3;
    localparam int EV_N        = BTN_N + 1;
    localparam int LEFT_W      = 12;
    localparam int SIZE_W      = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int PADDR_W     = 4;

    localparam logic [BTN_N-1:0]  BUTTON_MASK    = 3'd7;
    localparam logic [SIZE_W-1:0] RST_WIDTH      = 13'd640;
    localparam logic [SIZE_W-1:0] RST_HEIGHT     = 13'd480;

    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_TOP    = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } t_reg_idx;

    typedef enum logic {
        EV_MOTION = 1'b0,
        EV_BUTTON = 1'b1
    } t_evt_kind;

    typedef struct packed {
        logic [LEFT_W-1:0] left;
        logic [LEFT_W-1:0] top;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } t_bounds;

    // bit 0 of evmask is motion, bit i+1 is button i
    typedef struct packed {
        logic [EV_N-1:0]  evmask;
        logic [BTN_N-1:0] btn;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } t_cmd;

endpackage

// ----- hdl/mpt_if.sv -----
interface mpt_in_if;
    logic              valid;
    logic              ready;
    logic [7:0]        button_byte;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;

    modport source (output valid, button_byte, delta_x, delta_y, input ready);
    modport sink   (input valid, button_byte, delta_x, delta_y, output ready);
endinterface

interface mpt_out_if;
    logic                      valid;
    logic                      ready;
    logic                      event_kind;
    logic [1:0]                button_index;
    logic                      button_pressed;
    logic [mpt_pkg::POS_W-1:0] position_x;
    logic [mpt_pkg::POS_W-1:0] position_y;
    logic                      last;

    modport source (output valid, event_kind, button_index, button_pressed,
                    position_x, position_y, last, input ready);
    modport sink   (input valid, event_kind, button_index, button_pressed,
                    position_x, position_y, last, output ready);
endinterface

// ----- hdl/mouse_pointer_tracker_top.sv -----
// Mouse pointer tracker.
// i_pkt takes one three-byte mouse packet per word (valid/ready). The pointer
// is moved by the signed deltas (Y subtracted), clamped to the bound rectangle
// set over the APB port, and the button bits are compared with the last ones.
// o_evt gives one word per event: a motion event when the position changed,
// then one button event per changed button, left to middle; last marks the
// final word of a packet. A packet that changes nothing gives no word.
// The first event of a packet passes the command queue, the pending-event
// register and the output register. Packets are accepted one per cycle, while
// the queue has room, into a four-word command queue; the event stage drains
// it at one event per cycle while o_evt is not stalled.
// A stalled o_evt holds its word; packets keep entering until the queue fills.
// Reset puts the pointer at (0,0), clears the buttons and the queue, and loads
// bounds left=0, top=0, width=640, height=480. Write bounds only when idle.
module mouse_pointer_tracker_top #(
    parameter int COORD_BITS = 13
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mpt_in_if.sink                      i_pkt,
    mpt_out_if.source                   o_evt,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mpt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mpt_pkg::*;

    t_bounds  r_bounds;
    t_cmd     q_in;
    t_cmd     q_head;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds.left   <= '0;
            r_bounds.top    <= '0;
            r_bounds.width  <= RST_WIDTH;
            r_bounds.height <= RST_HEIGHT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_LEFT:   r_bounds.left   <= pwdata[LEFT_W-1:0];
                REG_TOP:    r_bounds.top    <= pwdata[LEFT_W-1:0];
                REG_WIDTH:  r_bounds.width  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: r_bounds.height <= pwdata[SIZE_W-1:0];
                default:    r_bounds        <= r_bounds;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LEFT:   prdata = 32'(r_bounds.left);
            REG_TOP:    prdata = 32'(r_bounds.top);
            REG_WIDTH:  prdata = 32'(r_bounds.width);
            REG_HEIGHT: prdata = 32'(r_bounds.height);
            default:    prdata = '0;
        endcase
    end

    mpt_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pkt    (i_pkt),
        .i_bounds (r_bounds),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_cmd    (q_in)
    );

    mpt_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mpt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_evt     (o_evt)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command queue underflow");

    a_motion_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.valid && (o_evt.event_kind == EV_MOTION))
        |-> (o_evt.button_index == 2'd0) && !o_evt.button_pressed)
        else $error("motion event carries button data");

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_evt.valid && !q_pop)
        else $error("activity right after reset");

endmodule

// ----- hdl/mpt_front.sv -----
module mpt_front #(
    parameter int COORD_BITS = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mpt_in_if.sink           i_pkt,
    input  mpt_pkg::t_bounds i_bounds,
    input  logic             i_q_full,
    output logic             o_q_push,
    output mpt_pkg::t_cmd    o_cmd
);
    import mpt_pkg::*;

    localparam int CW = ((COORD_BITS > 14) ? COORD_BITS : 14) + 2;
    localparam logic signed [CW-1:0] CMAX = CW'((2 ** COORD_BITS) - 1);

    logic [COORD_BITS-1:0] r_col, n_col;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic [BTN_N-1:0]      r_btn, n_btn;
    logic                  accept;
    logic                  moved;
    logic [BTN_N-1:0]      changed;
    logic [POS_W+COORD_BITS-1:0] ext_x, ext_y;

    function automatic logic [COORD_BITS-1:0] clamp_axis(
        input logic signed [CW-1:0] v,
        input logic [LEFT_W-1:0]    low,
        input logic [SIZE_W-1:0]    size
    );
        logic signed [CW-1:0] lo;
        logic signed [CW-1:0] hi;
        logic signed [CW-1:0] r;
        lo = signed'(CW'(low));
        hi = lo + signed'(CW'((size == '0) ? SIZE_W'(1) : size)) - CW'(1);
        if (lo > CMAX) lo = CMAX;
        if (hi > CMAX) hi = CMAX;
        r = v;
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r[COORD_BITS-1:0];
    endfunction

    assign i_pkt.ready = !i_q_full;
    assign accept      = i_pkt.valid && i_pkt.ready;

    always_comb begin
        n_col = clamp_axis(signed'(CW'(r_col)) + CW'(i_pkt.delta_x),
                           i_bounds.left, i_bounds.width);
        n_row = clamp_axis(signed'(CW'(r_row)) - CW'(i_pkt.delta_y),
                           i_bounds.top, i_bounds.height);
        n_btn = i_pkt.button_byte[BTN_N-1:0] & BUTTON_MASK;
    end

    assign moved   = (n_col != r_col) || (n_row != r_row);
    assign changed = n_btn ^ r_btn;

    // position fields carry the low POS_W bits, zero-extended when narrower
    assign ext_x = {{POS_W{1'b0}}, n_col};
    assign ext_y = {{POS_W{1'b0}}, n_row};

    always_comb begin
        o_cmd.evmask = {changed, moved};
        o_cmd.btn    = n_btn;
        o_cmd.pos_x  = ext_x[POS_W-1:0];
        o_cmd.pos_y  = ext_y[POS_W-1:0];
    end

    // drop packets that change nothing
    assign o_q_push = accept && (moved || (changed != '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_btn <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_btn <= n_btn;
        end
    end

endmodule

// ----- hdl/mpt_fifo.sv -----
module mpt_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mpt_pkg::t_cmd i_data,
    input  logic          i_pop,
    output mpt_pkg::t_cmd o_head,
    output logic          o_full,
    output logic          o_empty
);
    import mpt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [PTR_W:0]   r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + PTR_W'(1);
            if (do_pop)  r_rptr <= r_rptr + PTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (PTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/mpt_back.sv -----
module mpt_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mpt_pkg::t_cmd i_head,
    input  logic          i_q_empty,
    output logic          o_q_pop,
    mpt_out_if.source     o_evt
);
    import mpt_pkg::*;

    localparam int SEL_W = $clog2(EV_N);

    t_cmd             r_cur;
    logic [EV_N-1:0]  r_pend, n_pend;
    logic             r_ovalid;
    logic             r_kind;
    logic [1:0]       r_idx;
    logic             r_pressed;
    logic [POS_W-1:0] r_px, r_py;
    logic             r_last;

    logic [SEL_W-1:0] sel;
    logic [EV_N-1:0]  rest;
    logic             adv;
    logic [1:0]       btn_idx;

    // lowest pending event goes first: motion, then buttons 0..2
    always_comb begin
        sel = '0;
        for (int i = EV_N - 1; i >= 0; i--) begin
            if (r_pend[i]) sel = SEL_W'(i);
        end
    end

    assign rest    = r_pend & ~(EV_N'(1) << sel);
    assign adv     = (r_pend != '0) && (!r_ovalid || o_evt.ready);
    assign btn_idx = 2'(sel - SEL_W'(1));
    assign o_q_pop = !i_q_empty && ((r_pend == '0) || (adv && (rest == '0)));

    always_comb begin
        if (o_q_pop) begin
            n_pend = i_head.evmask;
        end else if (adv) begin
            n_pend = rest;
        end else begin
            n_pend = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (adv) begin
                r_ovalid <= 1'b1;
            end else if (o_evt.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_head;
        end
        if (adv) begin
            if (sel == '0) begin
                r_kind    <= EV_MOTION;
                r_idx     <= '0;
                r_pressed <= 1'b0;
            end else begin
                r_kind    <= EV_BUTTON;
                r_idx     <= btn_idx;
                r_pressed <= r_cur.btn[btn_idx];
            end
            r_px   <= r_cur.pos_x;
            r_py   <= r_cur.pos_y;
            r_last <= (rest == '0);
        end
    end

    assign o_evt.valid          = r_ovalid;
    assign o_evt.event_kind     = r_kind;
    assign o_evt.button_index   = r_idx;
    assign o_evt.button_pressed = r_pressed;
    assign o_evt.position_x     = r_px;
    assign o_evt.position_y     = r_py;
    assign o_evt.last           = r_last;

endmodule
